// ===== rtl/mec_pkg.sv =====
// ----------------------------------------------------------------------------
// mec_pkg
// Shared types and constants for the mouse event classifier.
// ----------------------------------------------------------------------------
package mec_pkg;

  localparam int COORD_BITS = 12;
  localparam int TICK_BITS  = 16;
  localparam int BTN_BITS   = 8;
  localparam int WHEEL_BITS = 4;
  localparam int MOD_BITS   = 16;
  localparam int DATA_BITS  = 16;
  localparam int ADDR_BITS  = 2;

  // register indexes on the configuration port
  localparam logic [ADDR_BITS-1:0] REG_EVENTS_ENABLED  = 2'd0;
  localparam logic [ADDR_BITS-1:0] REG_DOUBLE_DELAY    = 2'd1;
  localparam logic [ADDR_BITS-1:0] REG_REPEAT_DELAY    = 2'd2;
  localparam logic [ADDR_BITS-1:0] REG_REVERSE_BUTTONS = 2'd3;

  // button masks
  localparam logic [BTN_BITS-1:0] BTN_NONE = 8'd0;
  localparam logic [BTN_BITS-1:0] BTN_BOTH = 8'd3;

  // bit positions in the last-event flags
  localparam int FL_MOVED  = 0;
  localparam int FL_DOUBLE = 1;
  localparam int FL_TRIPLE = 2;

  // bit positions in the press flags
  localparam int PF_DOUBLE = 0;
  localparam int PF_TRIPLE = 1;

  typedef enum logic [2:0] {
    EV_NONE  = 3'd0,
    EV_DOWN  = 3'd1,
    EV_UP    = 3'd2,
    EV_MOVE  = 3'd3,
    EV_AUTO  = 3'd4,
    EV_WHEEL = 3'd5
  } ev_kind_t;

  typedef struct packed {
    logic                  sample_valid;
    logic [BTN_BITS-1:0]   in_buttons;
    logic [COORD_BITS-1:0] in_x;
    logic [COORD_BITS-1:0] in_y;
    logic [WHEEL_BITS-1:0] in_wheel;
    logic [MOD_BITS-1:0]   in_modifiers;
    logic [TICK_BITS-1:0]  tick_count;
  } in_item_t;

  typedef struct packed {
    ev_kind_t              event_kind;
    logic [BTN_BITS-1:0]   out_buttons;
    logic [COORD_BITS-1:0] out_x;
    logic [COORD_BITS-1:0] out_y;
    logic [WHEEL_BITS-1:0] out_wheel;
    logic [MOD_BITS-1:0]   out_modifiers;
    logic                  moved_flag;
    logic                  double_flag;
    logic                  triple_flag;
  } out_item_t;

  typedef struct packed {
    logic                 events_enabled;
    logic [TICK_BITS-1:0] double_delay;
    logic [TICK_BITS-1:0] repeat_delay;
    logic                 reverse_buttons;
  } cfg_t;

  typedef struct packed {
    logic [BTN_BITS-1:0]   last_buttons;
    logic [COORD_BITS-1:0] last_x;
    logic [COORD_BITS-1:0] last_y;
    logic [WHEEL_BITS-1:0] last_wheel;
    logic [2:0]            last_flags;
    logic [MOD_BITS-1:0]   last_modifiers;
    logic [BTN_BITS-1:0]   press_buttons;
    logic [COORD_BITS-1:0] press_x;
    logic [COORD_BITS-1:0] press_y;
    logic [1:0]            press_flags;
    logic [TICK_BITS-1:0]  press_time;
    logic [TICK_BITS-1:0]  repeat_time;
    logic [TICK_BITS-1:0]  repeat_wait;
    logic                  up_pending;
  } state_t;

endpackage

// ===== rtl/mec_cfg_regs.sv =====
// ----------------------------------------------------------------------------
// mec_cfg_regs
// Configuration registers, written through a plain write port.
// ----------------------------------------------------------------------------
module mec_cfg_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          cfg_we,
  input  logic [mec_pkg::ADDR_BITS-1:0] cfg_addr,
  input  logic [mec_pkg::DATA_BITS-1:0] cfg_wdata,
  output mec_pkg::cfg_t                 cfg
);

  mec_pkg::cfg_t cfg_r;
  mec_pkg::cfg_t cfg_nxt;

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      case (cfg_addr)
        mec_pkg::REG_EVENTS_ENABLED:  cfg_nxt.events_enabled  = cfg_wdata[0];
        mec_pkg::REG_DOUBLE_DELAY:
          cfg_nxt.double_delay = cfg_wdata[mec_pkg::TICK_BITS-1:0];
        mec_pkg::REG_REPEAT_DELAY:
          cfg_nxt.repeat_delay = cfg_wdata[mec_pkg::TICK_BITS-1:0];
        mec_pkg::REG_REVERSE_BUTTONS: cfg_nxt.reverse_buttons = cfg_wdata[0];
        default: cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.events_enabled  <= 1'b1;
      cfg_r.double_delay    <= mec_pkg::TICK_BITS'(8);
      cfg_r.repeat_delay    <= mec_pkg::TICK_BITS'(8);
      cfg_r.reverse_buttons <= 1'b0;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  assign cfg = cfg_r;

endmodule

// ===== rtl/mec_classify.sv =====
// ----------------------------------------------------------------------------
// mec_classify
// Classifies one poll against the tracked mouse state, giving the event and
// the next state.
// ----------------------------------------------------------------------------
module mec_classify (
  input  mec_pkg::in_item_t  item,
  input  mec_pkg::cfg_t      cfg,
  input  mec_pkg::state_t    st,
  output mec_pkg::out_item_t res,
  output mec_pkg::state_t    st_nxt
);

  logic [mec_pkg::BTN_BITS-1:0]  btn;
  logic                          same_spot;
  logic                          same_press;
  logic [mec_pkg::TICK_BITS-1:0] press_dt;
  logic [mec_pkg::TICK_BITS-1:0] repeat_dt;
  logic                          dbl;
  logic                          trp;

  always_comb begin
    btn = item.in_buttons;
    if (cfg.reverse_buttons && btn != mec_pkg::BTN_NONE && btn != mec_pkg::BTN_BOTH) begin
      btn = btn ^ mec_pkg::BTN_BOTH;
    end
  end

  // tick differences wrap naturally at the tick width
  assign press_dt   = item.tick_count - st.press_time;
  assign repeat_dt  = item.tick_count - st.repeat_time;
  assign same_spot  = (item.in_x == st.last_x) && (item.in_y == st.last_y);
  assign same_press = (btn == st.press_buttons) && (item.in_x == st.press_x) &&
                      (item.in_y == st.press_y) && (press_dt <= cfg.double_delay);
  assign dbl = same_press && (st.press_flags == 2'b00);
  assign trp = same_press && st.press_flags[mec_pkg::PF_DOUBLE];

  always_comb begin
    st_nxt = st;
    res    = '0;
    if (!cfg.events_enabled) begin
      res.event_kind = mec_pkg::EV_NONE;
    end else if (st.up_pending) begin
      // held-back up from a release that came with a move
      res.event_kind    = mec_pkg::EV_UP;
      res.out_buttons   = st.last_buttons;
      res.out_x         = st.last_x;
      res.out_y         = st.last_y;
      res.out_wheel     = st.last_wheel;
      res.out_modifiers = st.last_modifiers;
      res.moved_flag    = st.last_flags[mec_pkg::FL_MOVED];
      res.double_flag   = st.last_flags[mec_pkg::FL_DOUBLE];
      res.triple_flag   = st.last_flags[mec_pkg::FL_TRIPLE];
      st_nxt.last_buttons = mec_pkg::BTN_NONE;
      st_nxt.up_pending   = 1'b0;
    end else if (!item.sample_valid) begin
      res.event_kind = mec_pkg::EV_NONE;
    end else if (btn == mec_pkg::BTN_NONE && st.last_buttons != mec_pkg::BTN_NONE) begin
      st_nxt.last_x         = item.in_x;
      st_nxt.last_y         = item.in_y;
      st_nxt.last_wheel     = item.in_wheel;
      st_nxt.last_modifiers = item.in_modifiers;
      st_nxt.last_flags     = 3'b000;
      if (same_spot) begin
        res.event_kind    = mec_pkg::EV_UP;
        res.out_buttons   = st.last_buttons;
        res.out_x         = item.in_x;
        res.out_y         = item.in_y;
        res.out_wheel     = item.in_wheel;
        res.out_modifiers = item.in_modifiers;
        st_nxt.last_buttons = mec_pkg::BTN_NONE;
      end else begin
        // report the move now, the up on the next poll
        res.event_kind    = mec_pkg::EV_MOVE;
        res.out_buttons   = st.last_buttons;
        res.out_x         = item.in_x;
        res.out_y         = item.in_y;
        res.out_wheel     = st.last_wheel;
        res.out_modifiers = st.last_modifiers;
        res.moved_flag    = 1'b1;
        res.double_flag   = st.last_flags[mec_pkg::FL_DOUBLE];
        res.triple_flag   = st.last_flags[mec_pkg::FL_TRIPLE];
        st_nxt.last_buttons = st.last_buttons;
        st_nxt.up_pending   = 1'b1;
      end
    end else if (btn != mec_pkg::BTN_NONE && st.last_buttons == mec_pkg::BTN_NONE) begin
      res.event_kind    = mec_pkg::EV_DOWN;
      res.out_buttons   = btn;
      res.out_x         = item.in_x;
      res.out_y         = item.in_y;
      res.out_wheel     = item.in_wheel;
      res.out_modifiers = item.in_modifiers;
      res.double_flag   = dbl;
      res.triple_flag   = trp;
      st_nxt.press_buttons = btn;
      st_nxt.press_x       = item.in_x;
      st_nxt.press_y       = item.in_y;
      st_nxt.press_flags   = {trp, dbl};
      st_nxt.press_time    = item.tick_count;
      st_nxt.repeat_time   = item.tick_count;
      st_nxt.repeat_wait   = cfg.repeat_delay;
      st_nxt.last_buttons   = btn;
      st_nxt.last_x         = item.in_x;
      st_nxt.last_y         = item.in_y;
      st_nxt.last_wheel     = item.in_wheel;
      st_nxt.last_modifiers = item.in_modifiers;
      st_nxt.last_flags     = {trp, dbl, 1'b0};
    end else begin
      // no press or release: wheel, move or auto-repeat, buttons as last seen
      res.out_buttons   = st.last_buttons;
      res.out_x         = item.in_x;
      res.out_y         = item.in_y;
      res.out_wheel     = item.in_wheel;
      res.out_modifiers = item.in_modifiers;
      if (item.in_wheel != '0 || !same_spot ||
          (st.last_buttons != mec_pkg::BTN_NONE && repeat_dt > st.repeat_wait)) begin
        st_nxt.last_x         = item.in_x;
        st_nxt.last_y         = item.in_y;
        st_nxt.last_wheel     = item.in_wheel;
        st_nxt.last_modifiers = item.in_modifiers;
        st_nxt.last_flags     = 3'b000;
      end
      if (item.in_wheel != '0) begin
        res.event_kind = mec_pkg::EV_WHEEL;
      end else if (!same_spot) begin
        res.event_kind = mec_pkg::EV_MOVE;
        res.moved_flag = 1'b1;
        st_nxt.last_flags[mec_pkg::FL_MOVED] = 1'b1;
      end else if (st.last_buttons != mec_pkg::BTN_NONE && repeat_dt > st.repeat_wait) begin
        res.event_kind     = mec_pkg::EV_AUTO;
        st_nxt.repeat_time = item.tick_count;
        st_nxt.repeat_wait = mec_pkg::TICK_BITS'(1);
      end else begin
        res = '0;
        res.event_kind = mec_pkg::EV_NONE;
      end
    end
  end

endmodule

// ===== rtl/mouse_event_classifier.sv =====
// ----------------------------------------------------------------------------
// mouse_event_classifier
// Turns polled raw mouse samples into one classified event per poll.
// ----------------------------------------------------------------------------
// Usage:
//   Each transaction on the in_ channel is one poll: sample_valid says whether
//   a raw sample rides with it. Each poll yields exactly one transaction on the
//   out_ channel (event_kind none when there is nothing to report).
//   A poll is captured in the input register, then classified against the
//   tracked state and written to the result register. Throughput is one poll
//   per cycle while out_ready is high; the classifier and the state update
//   sit in a single stage between the input and result registers.
//   When out_ready is low the result register holds, the input register fills
//   and in_ready drops; nothing is lost or repeated.
//   Reset (rst_n low, synchronous) clears the tracked state and the valid
//   flags and loads the registers with enabled, double and repeat delays of
//   8 ticks and no button swap. Configuration writes take effect the next
//   cycle and are meant to be made while no poll is in flight.
// ----------------------------------------------------------------------------
module mouse_event_classifier (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_ready,
  input  mec_pkg::in_item_t             in_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output mec_pkg::out_item_t            out_data,
  input  logic                          cfg_we,
  input  logic [mec_pkg::ADDR_BITS-1:0] cfg_addr,
  input  logic [mec_pkg::DATA_BITS-1:0] cfg_wdata
);

  mec_pkg::cfg_t      cfg;
  mec_pkg::in_item_t  in_data_r;
  logic               in_valid_r;
  mec_pkg::out_item_t out_data_r;
  logic               out_valid_r;
  mec_pkg::state_t    st_r;
  mec_pkg::state_t    st_nxt;
  mec_pkg::out_item_t res;
  logic               adv;

  mec_cfg_regs u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata),
    .cfg       (cfg)
  );

  mec_classify u_classify (
    .item   (in_data_r),
    .cfg    (cfg),
    .st     (st_r),
    .res    (res),
    .st_nxt (st_nxt)
  );

  // result register free or being emptied this cycle
  assign adv      = !out_valid_r || out_ready;
  assign in_ready = !in_valid_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
    end else begin
      if (in_ready) begin
        in_valid_r <= in_valid;
      end
      if (adv) begin
        out_valid_r <= in_valid_r;
      end
      if (in_valid_r && adv) begin
        st_r <= st_nxt;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      in_data_r <= in_data;
    end
    if (in_valid_r && adv) begin
      out_data_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

// ===== bench/mouse_event_classifier_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// mouse_event_classifier_tb
// Drives polls with and without raw mouse samples through the classifier and
// checks every event against a tracked copy of the pointer and click state,
// across several register settings, with random idling on both channels.
// ----------------------------------------------------------------------------
module mouse_event_classifier_tb;

  localparam int CYCLE_LIMIT = 400000;

  typedef struct packed {
    logic [mec_pkg::BTN_BITS-1:0]   buttons;
    logic [mec_pkg::COORD_BITS-1:0] x;
    logic [mec_pkg::COORD_BITS-1:0] y;
    logic [mec_pkg::WHEEL_BITS-1:0] wheel;
    logic [mec_pkg::MOD_BITS-1:0]   mods;
    logic [2:0]                     flags;
  } ptr_sample_t;

  logic                          clk;
  logic                          rst_n     = 1'b0;
  logic                          in_valid  = 1'b0;
  logic                          in_ready;
  mec_pkg::in_item_t             in_data   = '0;
  logic                          out_valid;
  logic                          out_ready = 1'b0;
  mec_pkg::out_item_t            out_data;
  logic                          cfg_we    = 1'b0;
  logic [mec_pkg::ADDR_BITS-1:0] cfg_addr  = '0;
  logic [mec_pkg::DATA_BITS-1:0] cfg_wdata = '0;

  mouse_event_classifier DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_addr  (cfg_addr),
    .cfg_wdata (cfg_wdata)
  );

  // tracked copy of the register settings
  logic                          en_cfg;
  logic [mec_pkg::TICK_BITS-1:0] dbl_delay_cfg;
  logic [mec_pkg::TICK_BITS-1:0] rpt_delay_cfg;
  logic                          swap_cfg;

  // tracked copy of the classifier state
  ptr_sample_t                    prev;
  logic [mec_pkg::BTN_BITS-1:0]   click_btn;
  logic [mec_pkg::COORD_BITS-1:0] click_x;
  logic [mec_pkg::COORD_BITS-1:0] click_y;
  logic [1:0]                     click_flags;
  logic [mec_pkg::TICK_BITS-1:0]  click_tick;
  logic [mec_pkg::TICK_BITS-1:0]  rep_tick;
  logic [mec_pkg::TICK_BITS-1:0]  rep_wait;
  logic                           up_owed;

  mec_pkg::in_item_t  poll_queue[$];
  mec_pkg::out_item_t pending_events[$];
  mec_pkg::out_item_t want_ev;
  int        polls_queued  = 0;
  int        polls_taken   = 0;
  int        mismatch_count = 0;
  int        cycle_count   = 0;
  int        send_gap      = 0;
  int        stall_left    = 0;
  logic      in_taken      = 1'b0;
  logic      idle_on       = 1'b1;

  // pointer walk for the random polls
  logic [mec_pkg::BTN_BITS-1:0]   gen_btn   = '0;
  logic [mec_pkg::BTN_BITS-1:0]   gen_press = 8'd1;
  logic [mec_pkg::COORD_BITS-1:0] gen_x     = 12'd300;
  logic [mec_pkg::COORD_BITS-1:0] gen_y     = 12'd300;
  logic [mec_pkg::TICK_BITS-1:0]  gen_tick  = '0;

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  function automatic mec_pkg::out_item_t make_event(mec_pkg::ev_kind_t kind, ptr_sample_t s);
    mec_pkg::out_item_t ev;
    ev = '0;
    if (kind != mec_pkg::EV_NONE) begin
      ev.event_kind    = kind;
      ev.out_buttons   = s.buttons;
      ev.out_x         = s.x;
      ev.out_y         = s.y;
      ev.out_wheel     = s.wheel;
      ev.out_modifiers = s.mods;
      ev.moved_flag    = s.flags[mec_pkg::FL_MOVED];
      ev.double_flag   = s.flags[mec_pkg::FL_DOUBLE];
      ev.triple_flag   = s.flags[mec_pkg::FL_TRIPLE];
    end
    return ev;
  endfunction

  function automatic mec_pkg::out_item_t classify_poll(mec_pkg::in_item_t p);
    ptr_sample_t                   s;
    ptr_sample_t                   r;
    logic                          same_spot;
    logic [mec_pkg::TICK_BITS-1:0] dt;
    s = '0;
    if (!en_cfg) return make_event(mec_pkg::EV_NONE, s);
    if (up_owed) begin
      r = prev;
      prev.buttons = mec_pkg::BTN_NONE;
      up_owed = 1'b0;
      return make_event(mec_pkg::EV_UP, r);
    end
    if (!p.sample_valid) return make_event(mec_pkg::EV_NONE, s);
    s.buttons = p.in_buttons;
    s.x       = p.in_x;
    s.y       = p.in_y;
    s.wheel   = p.in_wheel;
    s.mods    = p.in_modifiers;
    if (swap_cfg && s.buttons != mec_pkg::BTN_NONE && s.buttons != mec_pkg::BTN_BOTH)
      s.buttons = s.buttons ^ mec_pkg::BTN_BOTH;
    same_spot = (s.x == prev.x) && (s.y == prev.y);

    if (s.buttons == mec_pkg::BTN_NONE && prev.buttons != mec_pkg::BTN_NONE) begin
      if (same_spot) begin
        r = s;
        r.buttons = prev.buttons;
        prev = s;
        return make_event(mec_pkg::EV_UP, r);
      end
      // release away from the last spot: move now, up on the next poll
      r = prev;
      r.x = s.x;
      r.y = s.y;
      r.flags[mec_pkg::FL_MOVED] = 1'b1;
      prev = s;
      prev.buttons = r.buttons;
      up_owed = 1'b1;
      return make_event(mec_pkg::EV_MOVE, r);
    end

    if (s.buttons != mec_pkg::BTN_NONE && prev.buttons == mec_pkg::BTN_NONE) begin
      dt = p.tick_count - click_tick;
      if (s.buttons == click_btn && s.x == click_x && s.y == click_y &&
          dt <= dbl_delay_cfg) begin
        if (click_flags == 2'b00)
          s.flags[mec_pkg::FL_DOUBLE] = 1'b1;
        else if (click_flags[mec_pkg::PF_DOUBLE])
          s.flags[mec_pkg::FL_TRIPLE] = 1'b1;
      end
      click_btn   = s.buttons;
      click_x     = s.x;
      click_y     = s.y;
      click_flags = '0;
      click_flags[mec_pkg::PF_DOUBLE] = s.flags[mec_pkg::FL_DOUBLE];
      click_flags[mec_pkg::PF_TRIPLE] = s.flags[mec_pkg::FL_TRIPLE];
      click_tick  = p.tick_count;
      rep_tick    = p.tick_count;
      rep_wait    = rpt_delay_cfg;
      prev = s;
      return make_event(mec_pkg::EV_DOWN, s);
    end

    s.buttons = prev.buttons;
    if (s.wheel != '0) begin
      prev = s;
      return make_event(mec_pkg::EV_WHEEL, s);
    end
    if (!same_spot) begin
      s.flags[mec_pkg::FL_MOVED] = 1'b1;
      prev = s;
      return make_event(mec_pkg::EV_MOVE, s);
    end
    dt = p.tick_count - rep_tick;
    if (s.buttons != mec_pkg::BTN_NONE && dt > rep_wait) begin
      rep_tick = p.tick_count;
      rep_wait = mec_pkg::TICK_BITS'(1);
      prev = s;
      return make_event(mec_pkg::EV_AUTO, s);
    end
    return make_event(mec_pkg::EV_NONE, s);
  endfunction

  // input side: drive at the falling edge
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_taken) begin
      in_taken = 1'b0;
      if (send_gap > 0) begin
        send_gap--;
        in_valid <= 1'b0;
      end else if (poll_queue.size() > 0) begin
        in_data  <= poll_queue.pop_front();
        in_valid <= 1'b1;
        if (idle_on && $urandom_range(0, 7) == 0) send_gap = $urandom_range(1, 19);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  always @(negedge clk) begin
    if (stall_left > 0) begin
      stall_left--;
      out_ready <= 1'b0;
    end else if (rst_n && idle_on && $urandom_range(0, 9) == 0) begin
      stall_left = $urandom_range(0, 18);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // both channels sampled at the rising edge
  always @(posedge clk) begin
    if (rst_n) begin
      if (in_valid && in_ready) begin
        pending_events.push_back(classify_poll(in_data));
        polls_taken++;
        in_taken = 1'b1;
      end
      if (out_valid && out_ready) begin
        if (pending_events.size() == 0) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display("unexpected transaction: kind=%0d btn=%h x=%h y=%h",
                     out_data.event_kind, out_data.out_buttons, out_data.out_x,
                     out_data.out_y);
        end else begin
          want_ev = pending_events.pop_front();
          if (out_data.event_kind    !== want_ev.event_kind    ||
              out_data.out_buttons   !== want_ev.out_buttons   ||
              out_data.out_x         !== want_ev.out_x         ||
              out_data.out_y         !== want_ev.out_y         ||
              out_data.out_wheel     !== want_ev.out_wheel     ||
              out_data.out_modifiers !== want_ev.out_modifiers ||
              out_data.moved_flag    !== want_ev.moved_flag    ||
              out_data.double_flag   !== want_ev.double_flag   ||
              out_data.triple_flag   !== want_ev.triple_flag) begin
            mismatch_count++;
            if (mismatch_count <= 10) begin
              $display("event mismatch at %0t", $realtime);
              $display("  expected kind=%0d btn=%h x=%h y=%h wh=%h mod=%h mdt=%b%b%b",
                       want_ev.event_kind, want_ev.out_buttons, want_ev.out_x,
                       want_ev.out_y, want_ev.out_wheel, want_ev.out_modifiers,
                       want_ev.moved_flag, want_ev.double_flag, want_ev.triple_flag);
              $display("  actual   kind=%0d btn=%h x=%h y=%h wh=%h mod=%h mdt=%b%b%b",
                       out_data.event_kind, out_data.out_buttons, out_data.out_x,
                       out_data.out_y, out_data.out_wheel, out_data.out_modifiers,
                       out_data.moved_flag, out_data.double_flag, out_data.triple_flag);
            end
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  task automatic queue_poll(logic v, logic [mec_pkg::BTN_BITS-1:0] btn,
                            logic [mec_pkg::COORD_BITS-1:0] x,
                            logic [mec_pkg::COORD_BITS-1:0] y,
                            logic [mec_pkg::WHEEL_BITS-1:0] wheel,
                            logic [mec_pkg::MOD_BITS-1:0] mods,
                            logic [mec_pkg::TICK_BITS-1:0] tick);
    mec_pkg::in_item_t p;
    p.sample_valid = v;
    p.in_buttons   = btn;
    p.in_x         = x;
    p.in_y         = y;
    p.in_wheel     = wheel;
    p.in_modifiers = mods;
    p.tick_count   = tick;
    poll_queue.push_back(p);
    polls_queued++;
  endtask

  // mostly well-formed click, hold, move and wheel sequences, some noise
  task automatic queue_random(int count);
    mec_pkg::in_item_t p;
    int                pick;
    for (int i = 0; i < count; i++) begin
      pick = $urandom_range(0, 99);
      p = '0;
      p.sample_valid = 1'b1;
      p.in_modifiers = mec_pkg::MOD_BITS'($urandom);
      if ($urandom_range(0, 24) == 0) gen_tick = mec_pkg::TICK_BITS'($urandom);
      else gen_tick = gen_tick + mec_pkg::TICK_BITS'($urandom_range(0, 10));
      if (pick < 14) begin
        p.sample_valid = (pick >= 6);
        p.in_buttons   = mec_pkg::BTN_BITS'($urandom);
        p.in_x         = mec_pkg::COORD_BITS'($urandom);
        p.in_y         = mec_pkg::COORD_BITS'($urandom);
        p.in_wheel     = mec_pkg::WHEEL_BITS'($urandom);
        p.tick_count   = mec_pkg::TICK_BITS'($urandom);
      end else begin
        if (pick < 48) begin
          if (gen_btn == mec_pkg::BTN_NONE) begin
            if ($urandom_range(0, 4) == 0) begin
              case ($urandom_range(0, 3))
                0: gen_press = 8'd1;
                1: gen_press = 8'd2;
                2: gen_press = 8'd3;
                default: gen_press = mec_pkg::BTN_BITS'($urandom_range(1, 255));
              endcase
            end
            gen_btn = gen_press;
          end else begin
            gen_btn = mec_pkg::BTN_NONE;
          end
          if ($urandom_range(0, 7) == 0) p.in_wheel = mec_pkg::WHEEL_BITS'($urandom);
        end else if (pick >= 62 && pick < 84) begin
          if (pick >= 74) gen_btn = mec_pkg::BTN_NONE;
          case ($urandom_range(0, 7))
            0: begin
              gen_x = mec_pkg::COORD_BITS'($urandom);
              gen_y = mec_pkg::COORD_BITS'($urandom);
            end
            1: begin
              gen_x = $urandom_range(0, 1) ? '1 : '0;
              gen_y = $urandom_range(0, 1) ? '1 : '0;
            end
            default: begin
              gen_x = gen_x + mec_pkg::COORD_BITS'($urandom_range(0, 3));
              gen_y = gen_y + mec_pkg::COORD_BITS'($urandom_range(1, 3));
            end
          endcase
        end else if (pick >= 84) begin
          p.in_wheel = mec_pkg::WHEEL_BITS'($urandom_range(1, 15));
        end
        p.in_buttons = gen_btn;
        p.in_x       = gen_x;
        p.in_y       = gen_y;
        p.tick_count = gen_tick;
      end
      poll_queue.push_back(p);
      polls_queued++;
    end
  endtask

  task automatic wait_idle();
    while (polls_taken != polls_queued || pending_events.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(logic [mec_pkg::ADDR_BITS-1:0] idx,
                           logic [mec_pkg::DATA_BITS-1:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= idx;
    cfg_wdata <= val;
    case (idx)
      mec_pkg::REG_EVENTS_ENABLED:  en_cfg        = val[0];
      mec_pkg::REG_DOUBLE_DELAY:    dbl_delay_cfg = val[mec_pkg::TICK_BITS-1:0];
      mec_pkg::REG_REPEAT_DELAY:    rpt_delay_cfg = val[mec_pkg::TICK_BITS-1:0];
      mec_pkg::REG_REVERSE_BUTTONS: swap_cfg      = val[0];
      default: ;
    endcase
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic run_phase(logic en, logic [mec_pkg::DATA_BITS-1:0] dd,
                           logic [mec_pkg::DATA_BITS-1:0] rd, logic rev, int count);
    write_reg(mec_pkg::REG_EVENTS_ENABLED, {{(mec_pkg::DATA_BITS-1){1'b0}}, en});
    write_reg(mec_pkg::REG_DOUBLE_DELAY, dd);
    write_reg(mec_pkg::REG_REPEAT_DELAY, rd);
    write_reg(mec_pkg::REG_REVERSE_BUTTONS, {{(mec_pkg::DATA_BITS-1){1'b0}}, rev});
    @(posedge clk);
    queue_random(count);
    wait_idle();
  endtask

  initial begin
    en_cfg        = 1'b1;
    dbl_delay_cfg = 16'd8;
    rpt_delay_cfg = 16'd8;
    swap_cfg      = 1'b0;
    prev          = '0;
    click_btn     = '0;
    click_x       = '0;
    click_y       = '0;
    click_flags   = '0;
    click_tick    = '0;
    rep_tick      = '0;
    rep_wait      = '0;
    up_owed       = 1'b0;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed polls on the reset settings
    queue_poll(1'b0, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd0);
    queue_poll(1'b1, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd1);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd10);
    queue_poll(1'b1, 8'h00, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd12);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd15);
    queue_poll(1'b1, 8'h00, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd16);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd18);
    queue_poll(1'b1, 8'h00, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd19);
    // press after a triple click carries no flag
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd20);
    // hold: exactly the repeat delay, then past it, then every other tick
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd28);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd29);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd30);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'h0, 16'h1234, 16'd31);
    queue_poll(1'b1, 8'h01, 12'd100, 12'd200, 4'hF, 16'hFFFF, 16'd31);
    queue_poll(1'b1, 8'h01, 12'd4095, 12'd4095, 4'h0, 16'hFFFF, 16'd32);
    // release with a move, then the held-back up ignores the sample given
    queue_poll(1'b1, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd33);
    queue_poll(1'b1, 8'hFF, 12'd5, 12'd5, 4'h1, 16'h5555, 16'd34);
    // double click across the tick wrap
    queue_poll(1'b1, 8'hFF, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd65534);
    queue_poll(1'b1, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd65535);
    queue_poll(1'b1, 8'hFF, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd3);
    queue_poll(1'b1, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd4);
    queue_poll(1'b1, 8'h80, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd5);
    queue_poll(1'b1, 8'h80, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd5);
    queue_poll(1'b1, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd6);
    wait_idle();
    queue_random(270);
    wait_idle();

    run_phase(1'b1, 16'd0, 16'd0, 1'b1, 250);
    run_phase(1'b1, 16'hFFFF, 16'hFFFF, 1'b0, 200);

    // leave an up held back across the disabled stretch
    queue_poll(1'b0, 8'h00, 12'd0, 12'd0, 4'h0, 16'h0000, 16'd0);
    queue_poll(1'b1, 8'h01, 12'd7, 12'd7, 4'h0, 16'h00A5, gen_tick);
    queue_poll(1'b1, 8'h00, 12'd9, 12'd9, 4'h0, 16'h005A, gen_tick);
    wait_idle();
    run_phase(1'b0, 16'd8, 16'd8, 1'b0, 50);
    run_phase(1'b1, 16'd3, 16'd2, 1'b1, 250);
    run_phase(1'b1, 16'd20, 16'd5, 1'b0, 250);

    // closing stretch at full rate
    idle_on = 1'b0;
    run_phase(1'b1, 16'd8, 16'd8, 1'b0, 250);

    repeat (8) @(posedge clk);
    if (mismatch_count == 0 && pending_events.size() == 0)
      $display("simulation ok");
    else
      $display("simulation failed");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/mec_pkg.sv
rtl/mec_cfg_regs.sv
rtl/mec_classify.sv
rtl/mouse_event_classifier.sv
bench/mouse_event_classifier_tb.sv
